@@ hw/rtl/hsvrgb_pkg.sv @@
// Shared constants, widths and sector codes for the HSV to RGB converter.
// Depends on nothing; the converter top level takes everything by scoped names.

package hsvrgb_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int HUE_BITS     = 15;
	localparam int REM_BITS     = 12;
	localparam int SEC_BITS     = 4;
	localparam int SECTOR_UNITS = 3840;
	localparam int FULL_CIRCLE  = 23040;
	localparam int MAX_SECTORS  = 8;

	localparam int CHAN_MAX  = (1 << CHANNEL_BITS) - 1;
	localparam int PROD_BITS = CHANNEL_BITS + REM_BITS;
	localparam int NUM_BITS  = 2 * CHANNEL_BITS + REM_BITS;
	localparam int PN_BITS   = 2 * CHANNEL_BITS;
	localparam int PS_BITS   = PN_BITS + 1;

	// 3840 is 15 << 8: drop the power of two, then multiply by the reciprocal of the rest
	localparam int UNIT_SHIFT  = 8;
	localparam int ODD_DIV     = (SECTOR_UNITS >> UNIT_SHIFT) * CHAN_MAX;
	localparam int QS_BITS     = NUM_BITS - UNIT_SHIFT;
	localparam int RECIP_SHIFT = QS_BITS + $clog2(ODD_DIV);
	localparam int RECIP_BITS  = QS_BITS + 1;
	localparam int MUL_BITS    = QS_BITS + RECIP_BITS;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(ODD_DIV) - 64'd1) / 64'(ODD_DIV);

	// input to result: five compute stages, one output stage
	localparam int LATENCY = 6;

	localparam logic [CHANNEL_BITS-1:0] CHAN_MAX_W = CHANNEL_BITS'(CHAN_MAX);
	localparam logic [REM_BITS-1:0]     SEC_UNITS_W = REM_BITS'(SECTOR_UNITS);
	localparam logic [HUE_BITS-1:0]     FULL_CIRCLE_W = HUE_BITS'(FULL_CIRCLE);
	localparam logic [PROD_BITS-1:0]    DEN_W = PROD_BITS'(CHAN_MAX * SECTOR_UNITS);
	localparam logic [RECIP_BITS-1:0]   RECIP_W = RECIP_BITS'(RECIP);

	localparam logic [SEC_BITS-1:0] SEC_RED_YELLOW    = 4'd0;
	localparam logic [SEC_BITS-1:0] SEC_YELLOW_GREEN  = 4'd1;
	localparam logic [SEC_BITS-1:0] SEC_GREEN_CYAN    = 4'd2;
	localparam logic [SEC_BITS-1:0] SEC_CYAN_BLUE     = 4'd3;
	localparam logic [SEC_BITS-1:0] SEC_BLUE_MAGENTA  = 4'd4;

endpackage

@@ hw/rtl/hsv_to_rgb_converter_top.sv @@
// HSV to RGB converter: sector split, products and constant-divisor pipelines.
// Depends on hsvrgb_pkg for widths, constants and sector codes.
//
// Usage:
//   Input word: hue (1/64 degree), saturation and brightness, taken at a rising
//   edge with start high and busy low. busy is always low: a word may enter in
//   every cycle, so the sustained rate is one pixel per clock.
//   Result word: red, green and blue appear for one cycle with done high,
//   once the word has passed the stage registers and the output register.
//   The receiver cannot stall; results leave in input order.
//   Stages: sector and remainder, saturation products, differences and the p
//   product, the q and t products, then reciprocal multiplies for q and t
//   (divisor 3840 times 2^CHANNEL_BITS-1, after a shift by 8) beside a
//   shift-add divide by 2^CHANNEL_BITS-1 for p, and a final register after
//   the sector select. The multiplier stages set the latency.
//   Reset clears the valid bits; words in flight are dropped and done stays low
//   until a new word has passed the whole pipeline.

module hsv_to_rgb_converter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [hsvrgb_pkg::HUE_BITS-1:0]      hue,
	input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  saturation,
	input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  brightness,
	output logic                                 done,
	output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  red,
	output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  green,
	output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  blue
);

	localparam int N = hsvrgb_pkg::CHANNEL_BITS;

	logic                                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [hsvrgb_pkg::SEC_BITS-1:0]      sec_s1, sec_s2, sec_s3, sec_s4, sec_s5;
	logic [N-1:0]                         val_s1, val_s2, val_s3, val_s4, val_s5;
	logic [N-1:0]                         sat_s1;
	logic [hsvrgb_pkg::REM_BITS-1:0]      rem_s1;
	logic [hsvrgb_pkg::PROD_BITS-1:0]     sr_s2, sc_s2;
	logic [N-1:0]                         mp_s2;
	logic [hsvrgb_pkg::PROD_BITS-1:0]     aq_s3, at_s3;
	logic [hsvrgb_pkg::PN_BITS-1:0]       pn_s3, pn_s4;
	logic [hsvrgb_pkg::NUM_BITS-1:0]      qn_s4, tn_s4;
	logic [hsvrgb_pkg::MUL_BITS-1:0]      qm_s5, tm_s5;
	logic [N-1:0]                         pq_s5;

	logic [hsvrgb_pkg::PS_BITS-1:0]       psum_c;
	logic [N-1:0]                         qq_c, tq_c;

	logic [hsvrgb_pkg::SEC_BITS-1:0]      sec_c;
	logic [hsvrgb_pkg::HUE_BITS-1:0]      base_c;
	logic [N-1:0]                         red_c, green_c, blue_c;
	logic [N-1:0]                         red_q, green_q, blue_q;
	logic                                 done_q;

	assign busy = 1'b0;

	// sector and remainder
	always_comb begin
		sec_c  = '0;
		base_c = '0;
		for (int k = 1; k <= hsvrgb_pkg::MAX_SECTORS; k++) begin
			if (hue >= hsvrgb_pkg::HUE_BITS'(k * hsvrgb_pkg::SECTOR_UNITS)) begin
				sec_c  = hsvrgb_pkg::SEC_BITS'(k);
				base_c = hsvrgb_pkg::HUE_BITS'(k * hsvrgb_pkg::SECTOR_UNITS);
			end
		end
		if (hue == hsvrgb_pkg::FULL_CIRCLE_W) begin
			sec_c = hsvrgb_pkg::SEC_RED_YELLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// divide by 2^N-1: (x + (x >> N) + 1) >> N
	assign psum_c = hsvrgb_pkg::PS_BITS'(pn_s4) + hsvrgb_pkg::PS_BITS'(pn_s4 >> N)
		+ hsvrgb_pkg::PS_BITS'(1);

	always_ff @(posedge clk) begin
		sec_s1 <= sec_c;
		rem_s1 <= hsvrgb_pkg::REM_BITS'(hue - base_c);
		sat_s1 <= saturation;
		val_s1 <= brightness;

		sec_s2 <= sec_s1;
		val_s2 <= val_s1;
		sr_s2  <= hsvrgb_pkg::PROD_BITS'(sat_s1) * hsvrgb_pkg::PROD_BITS'(rem_s1);
		sc_s2  <= hsvrgb_pkg::PROD_BITS'(sat_s1)
			* hsvrgb_pkg::PROD_BITS'(hsvrgb_pkg::SEC_UNITS_W - rem_s1);
		mp_s2  <= hsvrgb_pkg::CHAN_MAX_W - sat_s1;

		sec_s3 <= sec_s2;
		val_s3 <= val_s2;
		aq_s3  <= hsvrgb_pkg::DEN_W - sr_s2;
		at_s3  <= hsvrgb_pkg::DEN_W - sc_s2;
		pn_s3  <= hsvrgb_pkg::PN_BITS'(val_s2) * hsvrgb_pkg::PN_BITS'(mp_s2);

		sec_s4 <= sec_s3;
		val_s4 <= val_s3;
		qn_s4  <= hsvrgb_pkg::NUM_BITS'(val_s3) * hsvrgb_pkg::NUM_BITS'(aq_s3);
		tn_s4  <= hsvrgb_pkg::NUM_BITS'(val_s3) * hsvrgb_pkg::NUM_BITS'(at_s3);
		pn_s4  <= pn_s3;

		sec_s5 <= sec_s4;
		val_s5 <= val_s4;
		qm_s5  <= hsvrgb_pkg::MUL_BITS'(qn_s4[hsvrgb_pkg::NUM_BITS-1:hsvrgb_pkg::UNIT_SHIFT])
			* hsvrgb_pkg::MUL_BITS'(hsvrgb_pkg::RECIP_W);
		tm_s5  <= hsvrgb_pkg::MUL_BITS'(tn_s4[hsvrgb_pkg::NUM_BITS-1:hsvrgb_pkg::UNIT_SHIFT])
			* hsvrgb_pkg::MUL_BITS'(hsvrgb_pkg::RECIP_W);
		pq_s5  <= psum_c[N +: N];
	end

	assign qq_c = qm_s5[hsvrgb_pkg::RECIP_SHIFT +: N];
	assign tq_c = tm_s5[hsvrgb_pkg::RECIP_SHIFT +: N];

	// sector select
	always_comb begin
		case (sec_s5)
			hsvrgb_pkg::SEC_RED_YELLOW: begin
				red_c = val_s5; green_c = tq_c; blue_c = pq_s5;
			end
			hsvrgb_pkg::SEC_YELLOW_GREEN: begin
				red_c = qq_c; green_c = val_s5; blue_c = pq_s5;
			end
			hsvrgb_pkg::SEC_GREEN_CYAN: begin
				red_c = pq_s5; green_c = val_s5; blue_c = tq_c;
			end
			hsvrgb_pkg::SEC_CYAN_BLUE: begin
				red_c = pq_s5; green_c = qq_c; blue_c = val_s5;
			end
			hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
				red_c = tq_c; green_c = pq_s5; blue_c = val_s5;
			end
			default: begin
				red_c = val_s5; green_c = pq_s5; blue_c = qq_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		red_q   <= red_c;
		green_q <= green_c;
		blue_q  <= blue_c;
	end

	assign done  = done_q;
	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(hsvrgb_pkg::LATENCY) done)
		else $error("accepted word did not come out after the pipeline latency");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, hsvrgb_pkg::LATENCY))
		else $error("result without an accepted word");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(start && saturation == '0) |-> ##(hsvrgb_pkg::LATENCY)
		(red == $past(brightness, hsvrgb_pkg::LATENCY)
		&& green == $past(brightness, hsvrgb_pkg::LATENCY)
		&& blue == $past(brightness, hsvrgb_pkg::LATENCY)))
		else $error("zero saturation did not give grey");

	a_value_kept: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(hsvrgb_pkg::LATENCY)
		(red == $past(brightness, hsvrgb_pkg::LATENCY)
		|| green == $past(brightness, hsvrgb_pkg::LATENCY)
		|| blue == $past(brightness, hsvrgb_pkg::LATENCY)))
		else $error("no channel carries the value level");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for hsv_to_rgb_converter_top: directed and random HSV words with bursty start,
// each RGB result checked against an in-bench fixed-point conversion in arrival order.
// Depends on hsvrgb_pkg and the converter RTL only.

module tb;

	localparam int CB = hsvrgb_pkg::CHANNEL_BITS;
	localparam int HB = hsvrgb_pkg::HUE_BITS;
	localparam longint unsigned UNITS = 64'(hsvrgb_pkg::SECTOR_UNITS);
	localparam longint unsigned CIRCLE = 64'(hsvrgb_pkg::FULL_CIRCLE);
	localparam longint unsigned CMAX = 64'(hsvrgb_pkg::CHAN_MAX);
	localparam int HUE_TOP = (1 << HB) - 1;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
	} pixel_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [HB-1:0] hue = '0;
	logic [CB-1:0] saturation = '0;
	logic [CB-1:0] brightness = '0;
	logic          busy;
	logic          done;
	logic [CB-1:0] red;
	logic [CB-1:0] green;
	logic [CB-1:0] blue;

	pixel_t pending_rgb[$];
	int     mismatches = 0;
	int     stalled_cycles = 0;
	int     burst_left = 0;
	bit     bursty = 1'b1;

	hsv_to_rgb_converter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always #6 clk = ~clk;

	function automatic pixel_t rgb_of(input logic [HB-1:0] h, input logic [CB-1:0] s,
		input logic [CB-1:0] v);
		longint unsigned hh, ss, vv, den, rm, p, q, t;
		logic [3:0] sector;
		pixel_t px;
		hh = 64'(h);
		ss = 64'(s);
		vv = 64'(v);
		if (ss == 0) begin
			px.red = v;
			px.green = v;
			px.blue = v;
			return px;
		end
		if (hh == CIRCLE)
			hh = 0;
		sector = 4'(hh / UNITS);
		rm = hh % UNITS;
		den = CMAX * UNITS;
		p = (vv * (CMAX - ss)) / CMAX;
		q = (vv * (den - ss * rm)) / den;
		t = (vv * (den - ss * (UNITS - rm))) / den;
		case (sector)
			hsvrgb_pkg::SEC_RED_YELLOW: begin
				px.red = v; px.green = CB'(t); px.blue = CB'(p);
			end
			hsvrgb_pkg::SEC_YELLOW_GREEN: begin
				px.red = CB'(q); px.green = v; px.blue = CB'(p);
			end
			hsvrgb_pkg::SEC_GREEN_CYAN: begin
				px.red = CB'(p); px.green = v; px.blue = CB'(t);
			end
			hsvrgb_pkg::SEC_CYAN_BLUE: begin
				px.red = CB'(p); px.green = CB'(q); px.blue = v;
			end
			hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
				px.red = CB'(t); px.green = CB'(p); px.blue = v;
			end
			default: begin
				px.red = v; px.green = CB'(p); px.blue = CB'(q);
			end
		endcase
		return px;
	endfunction

	always @(posedge clk) begin : check_rgb
		pixel_t want;
		if (done) begin
			if (pending_rgb.size() == 0) begin
				mismatches++;
				$error("result word with none expected: %0d %0d %0d", red, green, blue);
			end else begin
				want = pending_rgb.pop_front();
				if (red !== want.red) begin
					mismatches++;
					$error("red: expected %0d, got %0d", want.red, red);
				end
				if (green !== want.green) begin
					mismatches++;
					$error("green: expected %0d, got %0d", want.green, green);
				end
				if (blue !== want.blue) begin
					mismatches++;
					$error("blue: expected %0d, got %0d", want.blue, blue);
				end
			end
		end
		if (start && !busy)
			pending_rgb.push_back(rgb_of(hue, saturation, brightness));
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_pixel(input logic [HB-1:0] h, input logic [CB-1:0] s,
		input logic [CB-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = 0;
			if (bursty)
				gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		hue <= h;
		saturation <= s;
		brightness <= v;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold start low until every expected word has come back
	task automatic drain;
		start <= 1'b0;
		while (pending_rgb.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [HB-1:0] random_hue;
		int k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return HB'($urandom_range(0, hsvrgb_pkg::FULL_CIRCLE));
		if (k == 7)
			return HB'($urandom_range(0, 6) * hsvrgb_pkg::SECTOR_UNITS + $urandom_range(0, 2) - 1);
		if (k == 8)
			return HB'($urandom_range(hsvrgb_pkg::FULL_CIRCLE + 1, HUE_TOP));
		return HB'($urandom_range(0, HUE_TOP));
	endfunction

	function automatic logic [CB-1:0] random_channel(input bit allow_zero);
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return allow_zero ? '0 : CB'(1);
		if (k == 1)
			return '1;
		if (k == 2)
			return CB'(1);
		return CB'($urandom_range(0, hsvrgb_pkg::CHAN_MAX));
	endfunction

	task automatic test_grey;
		send_pixel('0, '0, '0);
		send_pixel(HB'(7000), '0, '1);
		send_pixel(HB'(HUE_TOP), '0, CB'(8'h5a));
		send_pixel(HB'(hsvrgb_pkg::FULL_CIRCLE), '0, CB'(8'ha5));
	endtask

	task automatic test_sectors;
		for (int i = 0; i < 6; i++)
			send_pixel(HB'(i * hsvrgb_pkg::SECTOR_UNITS + hsvrgb_pkg::SECTOR_UNITS / 2), '1, '1);
		send_pixel(HB'(hsvrgb_pkg::SECTOR_UNITS - 1), '1, '1);
		send_pixel(HB'(hsvrgb_pkg::SECTOR_UNITS), '1, '1);
		send_pixel(HB'(3 * hsvrgb_pkg::SECTOR_UNITS + 1), CB'(1), '1);
		send_pixel(HB'(5 * hsvrgb_pkg::SECTOR_UNITS + 100), '1, '0);
		send_pixel(HB'(2 * hsvrgb_pkg::SECTOR_UNITS + 1234), CB'(8'h80), CB'(8'hc3));
	endtask

	task automatic test_hue_wrap;
		send_pixel('0, CB'(8'hc0), CB'(8'he0));
		send_pixel(HB'(hsvrgb_pkg::FULL_CIRCLE), CB'(8'hc0), CB'(8'he0));
		send_pixel(HB'(hsvrgb_pkg::FULL_CIRCLE - 1), '1, '1);
		send_pixel(HB'(hsvrgb_pkg::FULL_CIRCLE + 1), '1, '1);
		send_pixel(HB'(7 * hsvrgb_pkg::SECTOR_UNITS + 5), CB'(8'h7f), '1);
		send_pixel(HB'(HUE_TOP), '1, '1);
		send_pixel(HB'(HUE_TOP), CB'(1), CB'(8'hfe));
	endtask

	task automatic test_random_colors(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(random_hue(), random_channel(1'b1), random_channel(1'b1));
	endtask

	task automatic test_back_to_back(input int count);
		bursty = 1'b0;
		for (int i = 0; i < count; i++)
			send_pixel(HB'($urandom_range(0, HUE_TOP)), random_channel(1'b1),
				CB'($urandom_range(0, hsvrgb_pkg::CHAN_MAX)));
		bursty = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_grey();
		test_sectors();
		test_hue_wrap();
		drain();
		test_random_colors(1100);
		drain();
		test_back_to_back(400);
		test_random_colors(230);
		drain();
		repeat (hsvrgb_pkg::LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && pending_rgb.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
